FILE: src/deq_pkg.sv
// deq_pkg: operation codes, status codes and field widths of the double-ended queue
// no dependencies; used by double_ended_queue_top, deq_checker and the testbench
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // element reported where there is none
  localparam logic [VALUE_W-1:0] NONE_VALUE = {VALUE_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REPORT     = 3'd4
  } mode_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

endpackage

`default_nettype wire

FILE: src/deq_ram.sv
// deq_ram: generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/double_ended_queue_top.sv
// double_ended_queue_top: bounded deque of signed 32-bit values in a ring ram
// depends on deq_pkg and deq_ram
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------------
//   command   start / busy         mode, value
//   result    done (one cycle)     popped_value, status, entry_count, is_empty,
//                                  front_value, back_value
//
// each command goes through an accept cycle and a fetch cycle: the accept cycle updates head and count, writes a push
// into the ring ram and issues the ram read of the new front or back entry; the
// fetch cycle takes the registered read data and loads the result registers.
// a new command can be accepted in the cycle that done is high, but not in the fetch
// cycle, while busy is high and the registered read data of the ring ram is awaited.
// rst (synchronous) empties the queue; ram contents are not cleared.
// the receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [deq_pkg::MODE_W-1:0]     mode,
  input  wire logic signed [deq_pkg::VALUE_W-1:0] value,
  output logic                                done,
  output logic signed [deq_pkg::VALUE_W-1:0]  popped_value,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic [deq_pkg::COUNT_W-1:0]         entry_count,
  output logic                                is_empty,
  output logic signed [deq_pkg::VALUE_W-1:0]  front_value,
  output logic signed [deq_pkg::VALUE_W-1:0]  back_value
);

  localparam int AW = $clog2(DEPTH);     // ring index width
  localparam int CW = $clog2(DEPTH + 1); // count width, holds DEPTH itself
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

  // (base + off) modulo DEPTH, both operands below DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[AW-1:0];
  endfunction

  // control state
  deq_pkg::state_t state, state_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;

  // cached end values, only meaningful while the queue holds entries
  logic [deq_pkg::VALUE_W-1:0] front, front_next;
  logic [deq_pkg::VALUE_W-1:0] back, back_next;

  // what the fetch cycle still has to finish
  logic [deq_pkg::VALUE_W-1:0] pend_popped, pend_popped_next;
  deq_pkg::status_t            pend_status, pend_status_next;
  logic                        rd_front, rd_front_next;
  logic                        rd_back, rd_back_next;

  // ring ram ports
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [deq_pkg::VALUE_W-1:0] rdata;

  logic accept;
  logic load_out;
  logic [CW-1:0] count_m2;
  logic [deq_pkg::VALUE_W-1:0] front_cur;
  logic [deq_pkg::VALUE_W-1:0] back_cur;

  deq_ram #(
    .WIDTH(deq_pkg::VALUE_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = deq_pkg::ST_FETCH;
        end
      end
      deq_pkg::ST_FETCH: begin
        state_next = deq_pkg::ST_IDLE;
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy     = 1'b0;
    accept   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      deq_pkg::ST_IDLE: begin
        accept = start;
      end
      deq_pkg::ST_FETCH: begin
        busy     = 1'b1;
        load_out = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // offset of the new back entry after a pop at the back
  assign count_m2 = count - CW'(2);

  // operation decode: pointer update, ram write and ram read address
  always_comb begin
    head_next        = head;
    count_next       = count;
    front_next       = front;
    back_next        = back;
    pend_popped_next = deq_pkg::NONE_VALUE;
    pend_status_next = deq_pkg::STATUS_OK;
    rd_front_next    = 1'b0;
    rd_back_next     = 1'b0;
    we               = 1'b0;
    waddr            = head;
    raddr            = head;
    unique case (mode)
      deq_pkg::MODE_PUSH_FRONT: begin
        if (count == DEPTH_CNT) begin
          pend_status_next = deq_pkg::STATUS_FULL;
        end else begin
          head_next  = (head == '0) ? LAST_IDX : head - AW'(1);
          we         = accept;
          waddr      = head_next;
          count_next = count + CW'(1);
          front_next = value;
          if (count == '0) begin
            back_next = value;
          end
        end
      end
      deq_pkg::MODE_PUSH_BACK: begin
        if (count == DEPTH_CNT) begin
          pend_status_next = deq_pkg::STATUS_FULL;
        end else begin
          we         = accept;
          waddr      = ring_add(head, count[AW-1:0]);
          count_next = count + CW'(1);
          back_next  = value;
          if (count == '0) begin
            front_next = value;
          end
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (count == '0) begin
          pend_status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          pend_popped_next = front;
          head_next        = ring_add(head, AW'(1));
          count_next       = count - CW'(1);
          raddr            = head_next;
          rd_front_next    = (count != CW'(1));
        end
      end
      deq_pkg::MODE_POP_BACK: begin
        if (count == '0) begin
          pend_status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          pend_popped_next = back;
          count_next       = count - CW'(1);
          raddr            = ring_add(head, count_m2[AW-1:0]);
          rd_back_next     = (count != CW'(1));
        end
      end
      default: begin
        // report only, unused codes too
        pend_status_next = deq_pkg::STATUS_OK;
      end
    endcase
  end

  // end values after the operation, refreshed from the ram where a pop moved them
  assign front_cur = rd_front ? rdata : front;
  assign back_cur  = rd_back ? rdata : back;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= load_out;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      front       <= front_next;
      back        <= back_next;
      pend_popped <= pend_popped_next;
      pend_status <= pend_status_next;
      rd_front    <= rd_front_next;
      rd_back     <= rd_back_next;
    end else if (load_out) begin
      front <= front_cur;
      back  <= back_cur;
    end
    if (load_out) begin
      popped_value <= pend_popped;
      status       <= pend_status;
      entry_count  <= deq_pkg::COUNT_W'(count);
      is_empty     <= (count == '0);
      front_value  <= (count == '0) ? deq_pkg::NONE_VALUE : front_cur;
      back_value   <= (count == '0) ? deq_pkg::NONE_VALUE : back_cur;
    end
  end

endmodule

`default_nettype wire

FILE: src/deq_checker.sv
// deq_checker: port-level checks of the double-ended queue over time
// depends on deq_pkg; bound to double_ended_queue_top
`timescale 1ns / 1ps
`default_nettype none

module deq_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                done,
  input wire logic signed [deq_pkg::VALUE_W-1:0]  popped_value,
  input wire logic [deq_pkg::STATUS_W-1:0]        status,
  input wire logic [deq_pkg::COUNT_W-1:0]         entry_count,
  input wire logic                                is_empty,
  input wire logic signed [deq_pkg::VALUE_W-1:0]  front_value,
  input wire logic signed [deq_pkg::VALUE_W-1:0]  back_value
);

  // an accepted command always yields its result after the fetch cycle
  a_busy_then_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 done)
    else $error("accepted command did not produce a result two cycles later");

  // a result is never shown while a command is still in flight
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an empty queue reports no count and no end values
  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    done && is_empty |-> entry_count == '0 &&
      front_value == deq_pkg::NONE_VALUE && back_value == deq_pkg::NONE_VALUE)
    else $error("empty queue reported stale contents");

  // a failed pop or push returns no popped value
  a_fail_no_pop: assert property (@(posedge clk) disable iff (rst)
    done && (status == deq_pkg::STATUS_EMPTY || status == deq_pkg::STATUS_FULL)
      |-> popped_value == deq_pkg::NONE_VALUE)
    else $error("failed operation returned a popped value");

  // a pop on an empty queue leaves it empty
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done && status == deq_pkg::STATUS_EMPTY |-> is_empty)
    else $error("pop on empty queue reported entries");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .popped_value(popped_value),
  .status      (status),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .front_value (front_value),
  .back_value  (back_value)
);

`default_nettype wire

FILE: dv/double_ended_queue_top_test.sv
// double_ended_queue_top_test: self-checking testbench for the bounded double-ended queue
// depends on deq_pkg and double_ended_queue_top; a scoreboard class keeps a shadow deque
`timescale 1ns / 1ps

module double_ended_queue_top_test;
  import deq_pkg::*;

  localparam int DEPTH            = 1024;
  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 10;
  // cycles with neither a command transfer nor a result before the run is called hung
  localparam int STALL_LIMIT      = 1000;
  // settle time after the last result
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PER_PHASE = 250;
  // pushes in the climb before the queue is drained again
  localparam int CLIMB_ITEMS      = 60;
  localparam int MAX_GAP          = 4;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // one result as the block reports it
  typedef struct packed {
    logic signed [VALUE_W-1:0] popped;
    status_t                   code;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
    logic signed [VALUE_W-1:0] front;
    logic signed [VALUE_W-1:0] back;
  } deq_result_t;

  // shadow deque plus the queue of results still owed by the block
  class deque_scoreboard;
    logic signed [VALUE_W-1:0] shadow[$];
    deq_result_t               awaited[$];
    int                        capacity;
    int                        mismatches;
    int                        results_seen;

    function new(int cap);
      capacity     = cap;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int level();
      return shadow.size();
    endfunction

    // apply one accepted command to the shadow and queue the result it owes
    function void note_command(logic [MODE_W-1:0] op, logic signed [VALUE_W-1:0] element);
      deq_result_t want;
      want.popped = NONE_VALUE;
      want.code   = STATUS_OK;
      case (op)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (shadow.size() >= capacity) begin
            want.code = STATUS_FULL;
          end else if (op == MODE_PUSH_FRONT) begin
            shadow.insert(0, element);
          end else begin
            shadow.insert(shadow.size(), element);
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (shadow.size() == 0) begin
            want.code = STATUS_EMPTY;
          end else if (op == MODE_POP_FRONT) begin
            want.popped = shadow[0];
            shadow.delete(0);
          end else begin
            want.popped = shadow[shadow.size()-1];
            shadow.delete(shadow.size()-1);
          end
        end
        default: ;  // report, and the spare codes behave like it
      endcase
      want.count = COUNT_W'(shadow.size());
      want.empty = (shadow.size() == 0);
      if (want.empty) begin
        want.front = NONE_VALUE;
        want.back  = NONE_VALUE;
      end else begin
        want.front = shadow[0];
        want.back  = shadow[shadow.size()-1];
      end
      awaited.insert(awaited.size(), want);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
      mismatches++;
    endtask

    // compare one result, field by field, with the oldest one owed
    task check_result(deq_result_t got);
      deq_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (got.popped !== want.popped)
        report_mismatch($sformatf("popped_value %0d, expected %0d", got.popped, want.popped));
      if (got.code !== want.code)
        report_mismatch($sformatf("status %0d, expected %0d", got.code, want.code));
      if (got.count !== want.count)
        report_mismatch($sformatf("entry_count %0d, expected %0d", got.count, want.count));
      if (got.empty !== want.empty)
        report_mismatch($sformatf("is_empty %0b, expected %0b", got.empty, want.empty));
      if (got.front !== want.front)
        report_mismatch($sformatf("front_value %0d, expected %0d", got.front, want.front));
      if (got.back !== want.back)
        report_mismatch($sformatf("back_value %0d, expected %0d", got.back, want.back));
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;
  logic                      done;
  logic signed [VALUE_W-1:0] popped_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;

  deque_scoreboard sb;
  int              sender_idle_pct;
  int              stall_cycles;

  double_ended_queue_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .value        (value),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .front_value  (front_value),
    .back_value   (back_value)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // results are sampled at the rising edge that ends their one valid cycle
  always @(posedge clk) begin : result_monitor
    deq_result_t seen;
    if (!rst && done) begin
      seen.popped = popped_value;
      seen.code   = status_t'(status);
      seen.count  = entry_count;
      seen.empty  = is_empty;
      seen.front  = front_value;
      seen.back   = back_value;
      sb.check_result(seen);
    end
  end

  // hang detector: any transfer or result resets the count
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // drive one command from a falling edge, hold it until the transfer,
  // then maybe drop start for a random gap
  task automatic send_command(logic [MODE_W-1:0] op, logic signed [VALUE_W-1:0] element);
    start <= 1'b1;
    mode  <= op;
    value <= element;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, element);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
    end
  endtask

  // element values lean on the extremes now and then
  function automatic logic signed [VALUE_W-1:0] pick_element();
    case ($urandom_range(7))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return NONE_VALUE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_push();
    return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
  endfunction

  function automatic logic [MODE_W-1:0] pick_pop();
    return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
  endfunction

  // one of the codes past report only
  function automatic logic [MODE_W-1:0] pick_spare();
    return MODE_W'($urandom_range((1 << MODE_W) - 1, MODE_REPORT + 1));
  endfunction

  // random mix, slightly push heavy so the level wanders up and down,
  // with occasional empty pops near the bottom
  task automatic run_random(int n_items);
    int                  roll;
    logic [MODE_W-1:0]   op;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 42) begin
        op = pick_push();
      end else if (roll < 80) begin
        op = pick_pop();
      end else if (roll < 93) begin
        op = MODE_REPORT;
      end else begin
        op = pick_spare();
      end
      send_command(op, pick_element());
    end
  endtask

  // climb with pushes from both ends, then drain from both ends
  // and pop once more on empty
  task automatic fill_and_drain();
    repeat (CLIMB_ITEMS) send_command(pick_push(), pick_element());
    send_command(MODE_REPORT, pick_element());
    repeat (sb.level() + 1) send_command(pick_pop(), pick_element());
  endtask

  initial begin
    sb              = new(DEPTH);
    rst             = 1'b1;
    start           = 1'b0;
    mode            = MODE_REPORT;
    value           = '0;
    sender_idle_pct = 18;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty queue first
    send_command(MODE_REPORT, VALUE_MAX);
    send_command(MODE_POP_FRONT, VALUE_MIN);
    send_command(MODE_POP_BACK, NONE_VALUE);
    // extremes at both ends, front push wraps the head below zero
    send_command(MODE_PUSH_FRONT, VALUE_MAX);
    send_command(MODE_PUSH_BACK, VALUE_MIN);
    send_command(MODE_PUSH_FRONT, NONE_VALUE);
    send_command(MODE_PUSH_BACK, '0);
    send_command(MODE_PUSH_BACK, 32'h5555_5555);
    send_command(MODE_PUSH_FRONT, 32'haaaa_aaaa);
    send_command(MODE_REPORT, '0);
    // spare codes act as report only
    send_command(MODE_W'(MODE_REPORT + 1), VALUE_MAX);
    send_command(MODE_W'(MODE_REPORT + 2), VALUE_MIN);
    send_command(MODE_W'(MODE_REPORT + 3), NONE_VALUE);
    // drain from both ends down to empty, then pop once more
    send_command(MODE_POP_BACK, VALUE_MAX);
    send_command(MODE_POP_FRONT, '0);
    send_command(MODE_POP_BACK, NONE_VALUE);
    send_command(MODE_POP_FRONT, VALUE_MIN);
    send_command(MODE_POP_FRONT, '0);
    send_command(MODE_POP_BACK, VALUE_MAX);
    send_command(MODE_POP_FRONT, '0);
    // single entry: front and back are the same element
    send_command(MODE_PUSH_BACK, 32'h1234_5678);
    send_command(MODE_POP_FRONT, '0);

    run_random(RANDOM_PER_PHASE);

    sender_idle_pct = 59;
    fill_and_drain();
    run_random(RANDOM_PER_PHASE);

    // back to back, with start never dropped between commands
    sender_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue_top.sv
src/deq_checker.sv
dv/double_ended_queue_top_test.sv
